// ===== sv/cgp_pkg.sv =====
// Package for the combining glyph placer: glyph classes, word and state types.
// No dependencies; used by cgp_place and combining_glyph_placer.
package cgp_pkg;

  localparam int unsigned CoordW = 16;

  // codes at or below this value are control codes and are dropped
  localparam logic [7:0] CodeCtrlMax = 8'd31;
  // bottom-right marks sit this many rows above the base bottom
  localparam logic [CoordW-1:0] BotRightLift = 16'd2;
  // extra lift of a top dot above the base top
  localparam logic [CoordW-1:0] TopDotLift = 16'd2;

  typedef enum logic [3:0] {
    CLS_NORMAL    = 4'd0,
    CLS_CHAR      = 4'd1,
    CLS_GLUE      = 4'd2,
    CLS_LEFT      = 4'd3,
    CLS_RIGHT     = 4'd4,
    CLS_TOP_L     = 4'd5,
    CLS_TOP_C     = 4'd6,
    CLS_TOP_R     = 4'd7,
    CLS_BOT_L     = 4'd8,
    CLS_BOT_C     = 4'd9,
    CLS_BOT_R     = 4'd10,
    CLS_TOP_DOT   = 4'd11,
    CLS_BOT_R_EX  = 4'd12
  } glyph_class_e;

  typedef struct packed {
    logic       new_run;
    logic [7:0] glyph_code;
    logic [3:0] glyph_class;
    logic [7:0] glyph_width;
    logic [7:0] glyph_top;
    logic [7:0] glyph_bottom;
    logic [7:0] glue_width;
    logic [7:0] drop_offset;
  } item_t;

  typedef struct packed {
    logic [CoordW-1:0] base_left;
    logic [CoordW-1:0] base_right;
    logic [CoordW-1:0] base_top;
    logic [CoordW-1:0] base_bottom;
    logic              base_valid;
    logic [CoordW-1:0] pen_x;
    logic [CoordW-1:0] saved_pen_x;
    logic [CoordW-1:0] width_sum;
  } state_t;

  typedef struct packed {
    logic              draw_enable;
    logic [CoordW-1:0] draw_x;
    logic [CoordW-1:0] draw_y;
    logic [CoordW-1:0] run_width;
  } result_t;

endpackage

// ===== sv/cgp_place.sv =====
// Placement logic for one glyph: next line state and the result word.
// Purely combinational; uses cgp_pkg types and class codes.
module cgp_place (
  input  cgp_pkg::item_t   item_i,
  input  cgp_pkg::state_t  state_i,
  input  logic [7:0]       gap_i,
  output cgp_pkg::state_t  state_o,
  output cgp_pkg::result_t res_o,
  output logic             emit_o
);

  always_comb begin
    cgp_pkg::state_t cur;
    cgp_pkg::state_t nxt;
    logic [15:0] w16, t16, b16, g16, d16, gap16, h16;
    logic [15:0] pen, x, y, diff, half, bot_new;
    logic draw, mark;

    cur = item_i.new_run ? '0 : state_i;
    nxt = cur;
    w16 = {8'b0, item_i.glyph_width};
    t16 = {8'b0, item_i.glyph_top};
    b16 = {8'b0, item_i.glyph_bottom};
    g16 = {8'b0, item_i.glue_width};
    d16 = {8'b0, item_i.drop_offset};
    gap16 = {8'b0, gap_i};
    h16 = b16 - t16;
    pen = cur.pen_x;
    x = '0;
    y = '0;
    draw = 1'b1;
    mark = 1'b0;
    emit_o = 1'b0;
    // centering offset: signed halving, truncated toward zero
    diff = cur.base_right - cur.base_left - w16;
    half = 16'($signed(diff + {15'b0, diff[15]}) >>> 1);
    bot_new = cur.base_bottom - d16;

    if (item_i.glyph_code > cgp_pkg::CodeCtrlMax &&
        item_i.glyph_class <= cgp_pkg::CLS_BOT_R_EX) begin
      emit_o = 1'b1;
      case (cgp_pkg::glyph_class_e'(item_i.glyph_class))
        cgp_pkg::CLS_NORMAL: begin
          x = pen;
          nxt.base_valid = 1'b0;
          pen = pen + w16 + gap16;
          nxt.width_sum = cur.width_sum + w16 + gap16;
        end
        cgp_pkg::CLS_CHAR: begin
          x = pen;
          nxt.base_left = pen;
          nxt.base_right = pen + w16;
          nxt.base_top = t16;
          nxt.base_bottom = b16;
          nxt.base_valid = 1'b1;
          pen = pen + w16 + gap16;
          nxt.width_sum = cur.width_sum + w16 + gap16;
        end
        cgp_pkg::CLS_GLUE, cgp_pkg::CLS_LEFT: begin
          x = pen;
          nxt.base_left = pen;
          nxt.base_right = pen +
            ((item_i.glyph_class == cgp_pkg::CLS_GLUE) ? w16 : g16);
          nxt.base_top = t16;
          nxt.base_bottom = b16;
          nxt.base_valid = 1'b1;
          pen = pen + g16;
          nxt.width_sum = cur.width_sum + g16;
        end
        cgp_pkg::CLS_RIGHT: begin
          pen = pen + g16 - w16;
          x = pen;
          nxt.base_left = pen + w16 - g16;
          nxt.base_right = pen + w16;
          nxt.base_top = t16;
          nxt.base_bottom = b16;
          nxt.base_valid = 1'b1;
          pen = pen + w16;
          nxt.width_sum = cur.width_sum + g16;
        end
        cgp_pkg::CLS_BOT_R: begin
          if (cur.base_valid) begin
            pen = cur.base_right - 16'd1;
            x = pen;
            y = cur.base_bottom - cgp_pkg::BotRightLift;
          end else begin
            draw = 1'b0;
          end
          nxt.base_right = cur.base_right + w16;
          pen = pen + w16 + 16'd1;
          nxt.width_sum = cur.width_sum + w16;
        end
        cgp_pkg::CLS_BOT_R_EX: begin
          if (cur.base_valid) begin
            pen = cur.base_right + g16 - w16;
            x = pen;
            y = bot_new;
          end else begin
            draw = 1'b0;
          end
          nxt.base_left = pen + w16 - g16;
          nxt.base_right = pen + w16;
          nxt.base_top = bot_new;
          nxt.base_bottom = bot_new + h16;
          nxt.base_valid = 1'b1;
          pen = pen + w16;
          nxt.width_sum = cur.width_sum + g16;
        end
        default: begin
          // top and bottom marks hang off the base box
          mark = 1'b1;
          if (!cur.base_valid) begin
            draw = 1'b0;
          end else begin
            case (cgp_pkg::glyph_class_e'(item_i.glyph_class))
              cgp_pkg::CLS_TOP_L, cgp_pkg::CLS_BOT_L: x = cur.base_left;
              cgp_pkg::CLS_TOP_R:                     x = cur.base_right - w16;
              default:                                x = cur.base_left + half;
            endcase
            case (cgp_pkg::glyph_class_e'(item_i.glyph_class))
              cgp_pkg::CLS_BOT_L, cgp_pkg::CLS_BOT_C: y = cur.base_bottom;
              cgp_pkg::CLS_TOP_DOT: y = cur.base_top - h16 - cgp_pkg::TopDotLift;
              default:              y = cur.base_top - h16;
            endcase
          end
        end
      endcase
      if (mark) begin
        nxt.pen_x = cur.saved_pen_x;
      end else begin
        nxt.pen_x = pen;
        nxt.saved_pen_x = pen;
      end
    end

    state_o = nxt;
    res_o.draw_enable = draw;
    res_o.draw_x = draw ? x : '0;
    res_o.draw_y = draw ? y : '0;
    res_o.run_width = nxt.width_sum;
  end

endmodule

// ===== sv/combining_glyph_placer.sv =====
// Top level of the combining glyph placer: input word register, line state,
// result register and handshakes. Depends on cgp_pkg and cgp_place.
//
// Takes one glyph word per clock unless intake stalls; the word passes the input
// word register, then the result register. A full result register stalls intake
// only when the consumer also stalls. Words with a control code or an undefined
// class give no result, but their new-run flag still clears the line state. The
// line state comes combinationally from registered state, which sets that rate.
// char_gap is written through char_gap_we_i and should change only when idle.
module combining_glyph_placer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        char_gap_we_i,
  input  logic [7:0]  char_gap_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        new_run_i,
  input  logic [7:0]  glyph_code_i,
  input  logic [3:0]  glyph_class_i,
  input  logic [7:0]  glyph_width_i,
  input  logic [7:0]  glyph_top_i,
  input  logic [7:0]  glyph_bottom_i,
  input  logic [7:0]  glue_width_i,
  input  logic [7:0]  drop_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        draw_enable_o,
  output logic [15:0] draw_x_o,
  output logic [15:0] draw_y_o,
  output logic [15:0] run_width_o
);

  logic             in_valid_q;
  cgp_pkg::item_t   item_q;
  logic             out_valid_q;
  cgp_pkg::result_t res_q;
  cgp_pkg::state_t  state_q;
  cgp_pkg::state_t  state_d;
  cgp_pkg::result_t res_d;
  logic [7:0]       gap_q;
  logic             emit;
  logic             advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  cgp_place u_place (
    .item_i  (item_q),
    .state_i (state_q),
    .gap_i   (gap_q),
    .state_o (state_d),
    .res_o   (res_d),
    .emit_o  (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (char_gap_we_i) begin
      gap_q <= char_gap_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{new_run: new_run_i, glyph_code: glyph_code_i,
                  glyph_class: glyph_class_i, glyph_width: glyph_width_i,
                  glyph_top: glyph_top_i, glyph_bottom: glyph_bottom_i,
                  glue_width: glue_width_i, drop_offset: drop_offset_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign draw_enable_o = res_q.draw_enable;
  assign draw_x_o      = res_q.draw_x;
  assign draw_y_o      = res_q.draw_y;
  assign run_width_o   = res_q.run_width;

  // intake stalls only when both stages hold a word
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q))
    else $error("intake stalled with a free stage");

  // a suppressed mark carries no coordinates
  a_suppress_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !draw_enable_o) |-> (draw_x_o == '0 && draw_y_o == '0))
    else $error("suppressed word has coordinates");

  // a dropped word with new-run leaves a cleared line
  a_drop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !emit && item_q.new_run) |=>
      (state_q.pen_x == '0 && state_q.width_sum == '0 && !state_q.base_valid))
    else $error("new run not cleared on dropped word");

  // a dropped word never produces a result
  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !emit) |=> !out_valid_o)
    else $error("result produced for dropped word");

endmodule

// ===== bench/combining_glyph_placer_test.sv =====
// Self-checking bench for combining_glyph_placer: directed rows, then random glyph runs
// under several char_gap settings and idle mixes, checked against an in-bench placement model.
// Depends on cgp_pkg and the combining_glyph_placer RTL.
module combining_glyph_placer_test;

  localparam logic [3:0] ClsUndefLo = 4'd13;
  localparam logic [3:0] ClsUndefHi = 4'd15;
  localparam int         StuckLimit = 2000;
  localparam int         DrainCycles = 8;
  localparam int         NumPhases = 8;
  localparam int         WordsPerPhase = 128;

  typedef struct {
    cgp_pkg::item_t   g;
    bit               fixed;
    cgp_pkg::result_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        char_gap_we_i;
  logic [7:0]  char_gap_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        new_run_i;
  logic [7:0]  glyph_code_i;
  logic [3:0]  glyph_class_i;
  logic [7:0]  glyph_width_i;
  logic [7:0]  glyph_top_i;
  logic [7:0]  glyph_bottom_i;
  logic [7:0]  glue_width_i;
  logic [7:0]  drop_offset_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        draw_enable_o;
  logic [15:0] draw_x_o;
  logic [15:0] draw_y_o;
  logic [15:0] run_width_o;

  // placement model state
  logic [15:0] box_l, box_r, box_t, box_b;
  logic        box_ok;
  logic [15:0] pen, pen_saved, run_w;
  logic [15:0] gap_cfg;

  cgp_pkg::result_t placement_q[$];
  dir_row_t         dir_rows[$];
  int               errors = 0;
  int               words_sent = 0;
  int               results_seen = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               stuck = 0;

  combining_glyph_placer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_gap_we_i (char_gap_we_i),
    .char_gap_i    (char_gap_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .new_run_i     (new_run_i),
    .glyph_code_i  (glyph_code_i),
    .glyph_class_i (glyph_class_i),
    .glyph_width_i (glyph_width_i),
    .glyph_top_i   (glyph_top_i),
    .glyph_bottom_i(glyph_bottom_i),
    .glue_width_i  (glue_width_i),
    .drop_offset_i (drop_offset_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .draw_enable_o (draw_enable_o),
    .draw_x_o      (draw_x_o),
    .draw_y_o      (draw_y_o),
    .run_width_o   (run_width_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_fail(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic cgp_pkg::item_t glyph(input bit nr, input logic [7:0] code,
                                           input logic [3:0] cls, input logic [7:0] w,
                                           input logic [7:0] t, input logic [7:0] b,
                                           input logic [7:0] gl, input logic [7:0] d);
    cgp_pkg::item_t g;
    g = '{nr, code, cls, w, t, b, gl, d};
    return g;
  endfunction

  function automatic cgp_pkg::result_t placed(input bit en, input logic [15:0] x,
                                              input logic [15:0] y, input logic [15:0] rw);
    cgp_pkg::result_t r;
    r = '{en, x, y, rw};
    return r;
  endfunction

  function automatic void clear_line();
    box_l = '0; box_r = '0; box_t = '0; box_b = '0; box_ok = 1'b0;
    pen = '0; pen_saved = '0; run_w = '0;
  endfunction

  function automatic bit predict_placement(input cgp_pkg::item_t g,
                                           output cgp_pkg::result_t r);
    logic [15:0]          w, t, b, gl, d, h, x, y, diff;
    logic signed [15:0]   half;
    bit                   draw, mark;
    cgp_pkg::glyph_class_e cls;
    w = {8'h00, g.glyph_width};
    t = {8'h00, g.glyph_top};
    b = {8'h00, g.glyph_bottom};
    gl = {8'h00, g.glue_width};
    d = {8'h00, g.drop_offset};
    h = b - t;
    x = '0;
    y = '0;
    draw = 1'b1;
    mark = 1'b0;
    r = '0;
    if (g.new_run) clear_line();
    if (g.glyph_code <= cgp_pkg::CodeCtrlMax || g.glyph_class > cgp_pkg::CLS_BOT_R_EX)
      return 1'b0;
    cls = cgp_pkg::glyph_class_e'(g.glyph_class);
    case (cls)
      cgp_pkg::CLS_NORMAL: begin
        x = pen;
        box_ok = 1'b0;
        pen = pen + w + gap_cfg;
        run_w = run_w + w + gap_cfg;
      end
      cgp_pkg::CLS_CHAR: begin
        x = pen;
        box_l = pen; box_r = pen + w; box_t = t; box_b = b; box_ok = 1'b1;
        pen = pen + w + gap_cfg;
        run_w = run_w + w + gap_cfg;
      end
      cgp_pkg::CLS_GLUE, cgp_pkg::CLS_LEFT: begin
        x = pen;
        box_l = pen;
        box_r = pen + ((cls == cgp_pkg::CLS_GLUE) ? w : gl);
        box_t = t; box_b = b; box_ok = 1'b1;
        pen = pen + gl;
        run_w = run_w + gl;
      end
      cgp_pkg::CLS_RIGHT: begin
        pen = pen + gl - w;
        x = pen;
        box_l = pen + w - gl; box_r = pen + w; box_t = t; box_b = b; box_ok = 1'b1;
        pen = pen + w;
        run_w = run_w + gl;
      end
      cgp_pkg::CLS_BOT_R: begin
        if (box_ok) begin
          pen = box_r - 16'd1;
          x = pen;
          y = box_b - cgp_pkg::BotRightLift;
        end else begin
          draw = 1'b0;
        end
        box_r = box_r + w;
        pen = pen + w + 16'd1;
        run_w = run_w + w;
      end
      cgp_pkg::CLS_BOT_R_EX: begin
        if (box_ok) begin
          pen = box_r + gl - w;
          x = pen;
          y = box_b - d;
        end else begin
          draw = 1'b0;
        end
        box_l = pen + w - gl;
        box_r = pen + w;
        box_t = box_b - d;
        box_b = box_t + h;
        box_ok = 1'b1;
        pen = pen + w;
        run_w = run_w + gl;
      end
      default: begin
        mark = 1'b1;
        if (!box_ok) begin
          draw = 1'b0;
        end else begin
          case (cls)
            cgp_pkg::CLS_TOP_L, cgp_pkg::CLS_BOT_L: x = box_l;
            cgp_pkg::CLS_TOP_R:                     x = box_r - w;
            default: begin
              diff = box_r - box_l - w;
              half = $signed(diff) / 2;
              x = box_l + half;
            end
          endcase
          if (cls == cgp_pkg::CLS_BOT_L || cls == cgp_pkg::CLS_BOT_C) y = box_b;
          else if (cls == cgp_pkg::CLS_TOP_DOT) y = box_t - h - cgp_pkg::TopDotLift;
          else                                  y = box_t - h;
        end
      end
    endcase
    if (mark) pen = pen_saved;
    else pen_saved = pen;
    r.draw_enable = draw;
    r.draw_x = draw ? x : 16'd0;
    r.draw_y = draw ? y : 16'd0;
    r.run_width = run_w;
    return 1'b1;
  endfunction

  function automatic cgp_pkg::item_t random_glyph();
    cgp_pkg::item_t g;
    int             pick;
    pick = $urandom_range(99);
    g.new_run = ($urandom_range(99) < 4);
    g.glyph_code = 8'($urandom_range(255, 32));
    g.glyph_width = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40));
    g.glyph_top = 8'($urandom);
    g.glyph_bottom = 8'($urandom);
    g.glue_width = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40));
    g.drop_offset = 8'($urandom);
    if (pick < 6) begin
      g.glyph_code = 8'($urandom_range(31));
      g.glyph_class = 4'($urandom);
    end else if (pick < 10) begin
      g.glyph_class = 4'($urandom_range(ClsUndefHi, ClsUndefLo));
    end else if (pick < 25) begin
      g.glyph_class = cgp_pkg::CLS_NORMAL;
    end else if (pick < 55) begin
      g.glyph_class = 4'($urandom_range(cgp_pkg::CLS_RIGHT, cgp_pkg::CLS_CHAR));
    end else begin
      g.glyph_class = 4'($urandom_range(cgp_pkg::CLS_BOT_R_EX, cgp_pkg::CLS_TOP_L));
    end
    return g;
  endfunction

  // called just after a falling edge; returns just after the falling edge past acceptance
  task automatic send_glyph(input cgp_pkg::item_t g, input bit fixed,
                            input cgp_pkg::result_t want);
    cgp_pkg::result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    new_run_i      <= g.new_run;
    glyph_code_i   <= g.glyph_code;
    glyph_class_i  <= g.glyph_class;
    glyph_width_i  <= g.glyph_width;
    glyph_top_i    <= g.glyph_top;
    glyph_bottom_i <= g.glyph_bottom;
    glue_width_i   <= g.glue_width;
    drop_offset_i  <= g.drop_offset;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (predict_placement(g, r)) placement_q.push_back(fixed ? want : r);
    @(negedge clk_i);
  endtask

  task automatic drain_and_set_gap(input logic [7:0] gap);
    in_valid_i <= 1'b0;
    while (placement_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    char_gap_we_i <= 1'b1;
    char_gap_i    <= gap;
    @(negedge clk_i);
    char_gap_we_i <= 1'b0;
    gap_cfg = {8'h00, gap};
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    cgp_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (placement_q.size() == 0) begin
        report_fail($sformatf("unexpected word en=%0b x=%h y=%h w=%h",
                              draw_enable_o, draw_x_o, draw_y_o, run_width_o));
      end else begin
        want = placement_q.pop_front();
        if (draw_enable_o !== want.draw_enable)
          report_fail($sformatf("draw_enable %b, want %b", draw_enable_o, want.draw_enable));
        if (draw_x_o !== want.draw_x)
          report_fail($sformatf("draw_x %h, want %h", draw_x_o, want.draw_x));
        if (draw_y_o !== want.draw_y)
          report_fail($sformatf("draw_y %h, want %h", draw_y_o, want.draw_y));
        if (run_width_o !== want.run_width)
          report_fail($sformatf("run_width %h, want %h", run_width_o, want.run_width));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= StuckLimit) begin
      $display("watchdog: no handshake for %0d cycles", StuckLimit);
      $display("combining_glyph_placer_test failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]     gap_plan [NumPhases];
    cgp_pkg::item_t g;
    int             counted;
    rst_ni = 1'b0;
    char_gap_we_i = 1'b0;
    char_gap_i = '0;
    in_valid_i = 1'b0;
    new_run_i = 1'b0;
    glyph_code_i = '0;
    glyph_class_i = '0;
    glyph_width_i = '0;
    glyph_top_i = '0;
    glyph_bottom_i = '0;
    glue_width_i = '0;
    drop_offset_i = '0;
    out_ready_i = 1'b1;
    gap_cfg = '0;
    clear_line();

    // directed rows, char_gap at reset value
    dir_rows.push_back('{glyph(0, 8'd32, cgp_pkg::CLS_NORMAL, 0, 0, 0, 0, 0), 1,
                         placed(1, 0, 0, 0)});
    dir_rows.push_back('{glyph(0, 8'd40, cgp_pkg::CLS_TOP_C, 9, 3, 7, 1, 0), 1,
                         placed(0, 0, 0, 0)});
    dir_rows.push_back('{glyph(1, cgp_pkg::CodeCtrlMax, cgp_pkg::CLS_CHAR, 5, 1, 2, 3, 4),
                         0, '0});
    dir_rows.push_back('{glyph(0, 8'd0, cgp_pkg::CLS_GLUE, 255, 255, 255, 255, 255), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd200, ClsUndefLo, 7, 1, 2, 3, 4), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd201, ClsUndefHi, 7, 1, 2, 3, 4), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd255, cgp_pkg::CLS_CHAR, 255, 0, 255, 0, 0), 1,
                         placed(1, 0, 0, 255)});
    dir_rows.push_back('{glyph(0, 8'd65, cgp_pkg::CLS_TOP_L, 4, 10, 20, 0, 0), 1,
                         placed(1, 0, 16'hFFF6, 255)});
    dir_rows.push_back('{glyph(0, 8'd66, cgp_pkg::CLS_TOP_C, 255, 0, 255, 0, 0), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd67, cgp_pkg::CLS_TOP_R, 6, 2, 9, 0, 0), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd68, cgp_pkg::CLS_BOT_L, 6, 2, 9, 0, 0), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd69, cgp_pkg::CLS_BOT_C, 3, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd70, cgp_pkg::CLS_TOP_DOT, 2, 255, 0, 0, 0), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd71, cgp_pkg::CLS_BOT_R, 5, 1, 3, 0, 0), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd72, cgp_pkg::CLS_BOT_R_EX, 9, 4, 30, 2, 255), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd73, cgp_pkg::CLS_TOP_C, 1, 0, 8, 0, 0), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd74, cgp_pkg::CLS_GLUE, 255, 255, 0, 255, 0), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd75, cgp_pkg::CLS_LEFT, 0, 7, 7, 255, 0), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd76, cgp_pkg::CLS_RIGHT, 200, 1, 2, 10, 0), 0, '0});
    dir_rows.push_back('{glyph(1, 8'd77, cgp_pkg::CLS_BOT_R, 255, 0, 0, 0, 0), 1,
                         placed(0, 0, 0, 255)});
    dir_rows.push_back('{glyph(1, 8'd78, cgp_pkg::CLS_BOT_R_EX, 3, 5, 9, 77, 6), 1,
                         placed(0, 0, 0, 77)});
    dir_rows.push_back('{glyph(0, 8'd79, cgp_pkg::CLS_TOP_L, 1, 1, 4, 0, 0), 0, '0});
    dir_rows.push_back('{glyph(1, 8'd80, ClsUndefLo, 1, 1, 1, 1, 1), 0, '0});
    dir_rows.push_back('{glyph(0, 8'd81, cgp_pkg::CLS_TOP_DOT, 1, 1, 1, 1, 1), 1,
                         placed(0, 0, 0, 0)});
    dir_rows.push_back('{glyph(1, 8'd100, cgp_pkg::CLS_RIGHT, 255, 0, 0, 0, 0), 1,
                         placed(1, 16'hFF01, 0, 0)});
    dir_rows.push_back('{glyph(0, 8'd255, cgp_pkg::CLS_NORMAL, 255, 255, 255, 255, 255), 0,
                         '0});

    gap_plan[0] = 8'd255;
    gap_plan[1] = 8'($urandom);
    gap_plan[2] = 8'd0;
    gap_plan[3] = 8'd1;
    gap_plan[4] = 8'($urandom);
    gap_plan[5] = 8'd128;
    gap_plan[6] = 8'($urandom);
    gap_plan[7] = 8'd255;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_glyph(dir_rows[i].g, dir_rows[i].fixed, dir_rows[i].want);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_and_set_gap(gap_plan[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      counted = 0;
      while (counted < WordsPerPhase) begin
        g = random_glyph();
        counted++;
        send_glyph(g, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (placement_q.size() != 0) report_fail("placements still outstanding at end");

    $display("sent %0d glyph words, checked %0d placement words, %0d char_gap phases",
             words_sent, results_seen, NumPhases);
    $display("phases mixed free flow, sender gaps and receiver stalls; %0d mismatches", errors);
    if (errors == 0) begin
      $display("combining_glyph_placer_test passed");
    end else begin
      $display("combining_glyph_placer_test failed");
    end
    $finish;
  end

endmodule
